// ----- rtl/core/trilinear_voxel_sampler_assert.svh -----
// Assertion macros used by tvs_checker, the bound checker of the voxel sampler.
// Each macro samples on the rising edge of clk and is off while rst is high.
`ifndef TRILINEAR_VOXEL_SAMPLER_ASSERT_SVH
`define TRILINEAR_VOXEL_SAMPLER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TVS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TVS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/tvs_pkg.sv -----
`default_nettype none

package tvs_pkg;

  // Build constants
  localparam int MAX_EXTENT = 64;
  localparam int FRAC_BITS  = 8;
  localparam int VOXEL_BITS = 16;

  // Fixed field widths of the channels
  localparam int POS_BITS       = 14;
  localparam int IDX_FIELD_BITS = 6;
  localparam int VALUE_BITS     = 16;
  localparam int CFG_BITS       = 7;
  localparam int CFG_IDX_BITS   = 2;

  // Volume addressing: eight parity banks, one per corner of a cell
  localparam int IDX_BITS       = $clog2(MAX_EXTENT);
  localparam int BANK_IDX_BITS  = IDX_BITS - 1;
  localparam int BANK_ADDR_BITS = 3 * BANK_IDX_BITS;
  localparam int BANK_DEPTH     = 1 << BANK_ADDR_BITS;
  localparam int BANK_SEL_BITS  = 3;
  localparam int NUM_BANKS      = 1 << BANK_SEL_BITS;
  localparam int CELL_BITS      = POS_BITS - FRAC_BITS;

  // Datapath widths after each blend
  localparam int NUM_LANES  = 4;
  localparam int LANE1_BITS = VOXEL_BITS + FRAC_BITS;
  localparam int LANE2_BITS = VOXEL_BITS + 2 * FRAC_BITS;
  localparam int LANE3_BITS = VOXEL_BITS + 3 * FRAC_BITS;
  localparam int EDGE_BITS  = (POS_BITS > CFG_BITS + FRAC_BITS) ? POS_BITS
                                                                : CFG_BITS + FRAC_BITS;

  localparam logic [FRAC_BITS:0]    WGT_ONE      = (FRAC_BITS + 1)'(1 << FRAC_BITS);
  localparam logic [POS_BITS-1:0]   POS_ONE      = POS_BITS'(1 << FRAC_BITS);
  localparam logic [CFG_BITS-1:0]   EXTENT_RESET = CFG_BITS'(64);

  // Commands
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_SLICE_COUNT  = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] CFG_WIDTH_IN_USE = CFG_IDX_BITS'(1);

  typedef struct packed {
    logic                      cmd;
    logic [IDX_FIELD_BITS-1:0] load_slice;
    logic [IDX_FIELD_BITS-1:0] load_row;
    logic [IDX_FIELD_BITS-1:0] load_col;
    logic [VALUE_BITS-1:0]     voxel_value;
    logic [POS_BITS-1:0]       pos_slice;
    logic [POS_BITS-1:0]       pos_row;
    logic [POS_BITS-1:0]       pos_col;
  } tvs_req_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] sample_value;
    logic                  near_edge;
  } tvs_rsp_t;

  // Limit an extent register to the built volume size
  function automatic logic [CFG_BITS-1:0] clamp_extent(input logic [CFG_BITS-1:0] n);
    if (int'(n) > MAX_EXTENT) begin
      return CFG_BITS'(MAX_EXTENT);
    end
    return n;
  endfunction

  // True when pos lies in the zero border of an axis of extent n
  function automatic logic in_border(input logic [POS_BITS-1:0] pos,
                                     input logic [CFG_BITS-1:0] n);
    logic [EDGE_BITS-1:0] limit;
    logic [EDGE_BITS-1:0] pos_w;
    limit = EDGE_BITS'(n - CFG_BITS'(2)) << FRAC_BITS;
    pos_w = EDGE_BITS'(pos);
    return (pos <= POS_ONE) || (n < CFG_BITS'(2)) || (pos_w >= limit);
  endfunction

  // Bank coordinate of the corner with parity b among cell index c and c+1
  function automatic logic [BANK_IDX_BITS-1:0] bank_coord(input logic [IDX_BITS-1:0] c,
                                                          input logic b);
    return c[IDX_BITS-1:1] + BANK_IDX_BITS'(c[0] & ~b);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/trilinear_voxel_sampler.sv -----
// Channel | Direction | Payload                 | Handshake
// req     | in        | tvs_req_t (load/sample) | req_valid / req_ready
// rsp     | out       | tvs_rsp_t               | rsp_valid / rsp_ready
// cfg     | in        | cfg_index, cfg_data     | cfg_valid / cfg_ready
//
// One beat per cycle on req while rsp is not stalled; a sample beat passes the
// input stage, bank read, slice blend, row blend and column blend into the
// output register before it shows on rsp. A load beat writes its bank when it
// leaves the input stage and gives no rsp beat. rst is synchronous, clears the
// valid bits and sets the extent registers to 64; the volume itself is
// undefined until loaded. Each stage advances when it is empty or the next one
// advances, so bubbles close up while rsp stalls. cfg_ready is always high.

`default_nettype none

module trilinear_voxel_sampler (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 req_valid,
  output logic                                 req_ready,
  input  tvs_pkg::tvs_req_t                    req,
  output logic                                 rsp_valid,
  input  logic                                 rsp_ready,
  output tvs_pkg::tvs_rsp_t                    rsp,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [tvs_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [tvs_pkg::CFG_BITS-1:0]         cfg_data
);

  // Extent registers
  logic [tvs_pkg::CFG_BITS-1:0] slice_count;
  logic [tvs_pkg::CFG_BITS-1:0] width_in_use;

  // Stage enables
  logic en_a, en_b, en_c, en_d, en_e;

  // Stage A: registered request
  logic                                      a_valid;
  tvs_pkg::tvs_req_t                         a_req;
  logic [tvs_pkg::IDX_BITS-1:0]              a_s0, a_r0, a_c0;
  logic                                      a_border;
  logic [tvs_pkg::BANK_SEL_BITS-1:0]         a_par;
  logic [tvs_pkg::BANK_ADDR_BITS-1:0]        a_raddr [tvs_pkg::NUM_BANKS];
  logic [tvs_pkg::IDX_BITS-1:0]              w_s, w_r, w_c;
  logic [tvs_pkg::BANK_SEL_BITS-1:0]         w_bank;
  logic [tvs_pkg::BANK_ADDR_BITS-1:0]        w_addr;
  logic [tvs_pkg::VOXEL_BITS-1:0]            w_data;
  logic                                      a_write;

  // Stage B: bank read data
  logic                                      b_valid;
  logic                                      b_border;
  logic [tvs_pkg::BANK_SEL_BITS-1:0]         b_par;
  logic [tvs_pkg::FRAC_BITS-1:0]             b_fs, b_fr, b_fc;
  logic [tvs_pkg::VOXEL_BITS-1:0]            b_rd [tvs_pkg::NUM_BANKS];
  logic [tvs_pkg::LANE1_BITS-1:0]            lane_next [tvs_pkg::NUM_LANES];

  // Stage C: slice blends
  logic                                      c_valid;
  logic                                      c_border;
  logic [tvs_pkg::FRAC_BITS-1:0]             c_fr, c_fc;
  logic [tvs_pkg::LANE1_BITS-1:0]            c_lane [tvs_pkg::NUM_LANES];
  logic [tvs_pkg::LANE2_BITS-1:0]            row_next [2];

  // Stage D: row blends
  logic                                      d_valid;
  logic                                      d_border;
  logic [tvs_pkg::FRAC_BITS-1:0]             d_fc;
  logic [tvs_pkg::LANE2_BITS-1:0]            d_row [2];
  logic [tvs_pkg::LANE3_BITS-1:0]            acc;
  tvs_pkg::tvs_rsp_t                         rsp_next;

  // Ready chain: a stage moves when empty or when its successor moves
  assign en_e      = !rsp_valid || rsp_ready;
  assign en_d      = !d_valid || en_e;
  assign en_c      = !c_valid || en_d;
  assign en_b      = !b_valid || en_c;
  assign en_a      = !a_valid || en_b;
  assign req_ready = en_a;
  assign cfg_ready = 1'b1;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      slice_count  <= tvs_pkg::EXTENT_RESET;
      width_in_use <= tvs_pkg::EXTENT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tvs_pkg::CFG_SLICE_COUNT:  slice_count  <= cfg_data;
        tvs_pkg::CFG_WIDTH_IN_USE: width_in_use <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage A register
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en_a) begin
      a_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      a_req <= req;
    end
  end

  // Border test, cell origin and the read address of each bank
  always_comb begin
    a_s0 = tvs_pkg::IDX_BITS'(a_req.pos_slice[tvs_pkg::POS_BITS-1:tvs_pkg::FRAC_BITS]);
    a_r0 = tvs_pkg::IDX_BITS'(a_req.pos_row[tvs_pkg::POS_BITS-1:tvs_pkg::FRAC_BITS]);
    a_c0 = tvs_pkg::IDX_BITS'(a_req.pos_col[tvs_pkg::POS_BITS-1:tvs_pkg::FRAC_BITS]);
    a_border = tvs_pkg::in_border(a_req.pos_slice, tvs_pkg::clamp_extent(slice_count))
            || tvs_pkg::in_border(a_req.pos_row, tvs_pkg::clamp_extent(width_in_use))
            || tvs_pkg::in_border(a_req.pos_col, tvs_pkg::clamp_extent(width_in_use));
    a_par = {a_s0[0], a_r0[0], a_c0[0]};
    for (int k = 0; k < tvs_pkg::NUM_BANKS; k++) begin
      a_raddr[k] = {tvs_pkg::bank_coord(a_s0, k[2]),
                    tvs_pkg::bank_coord(a_r0, k[1]),
                    tvs_pkg::bank_coord(a_c0, k[0])};
    end
  end

  // Load write: bank by index parity, address by index halves
  always_comb begin
    w_s     = tvs_pkg::IDX_BITS'(a_req.load_slice);
    w_r     = tvs_pkg::IDX_BITS'(a_req.load_row);
    w_c     = tvs_pkg::IDX_BITS'(a_req.load_col);
    w_bank  = {w_s[0], w_r[0], w_c[0]};
    w_addr  = {w_s[tvs_pkg::IDX_BITS-1:1], w_r[tvs_pkg::IDX_BITS-1:1],
               w_c[tvs_pkg::IDX_BITS-1:1]};
    w_data  = a_req.voxel_value[tvs_pkg::VOXEL_BITS-1:0];
    a_write = a_valid && en_b && (a_req.cmd == tvs_pkg::CMD_LOAD)
           && (int'(a_req.load_slice) < tvs_pkg::MAX_EXTENT)
           && (int'(a_req.load_row) < tvs_pkg::MAX_EXTENT)
           && (int'(a_req.load_col) < tvs_pkg::MAX_EXTENT);
  end

  // Voxel banks: one write port, one registered read port each
  for (genvar k = 0; k < tvs_pkg::NUM_BANKS; k++) begin : g_bank
    logic [tvs_pkg::VOXEL_BITS-1:0] mem [tvs_pkg::BANK_DEPTH];

    always_ff @(posedge clk) begin
      if (a_write && (w_bank == tvs_pkg::BANK_SEL_BITS'(k))) begin
        mem[w_addr] <= w_data;
      end
      if (en_b) begin
        b_rd[k] <= mem[a_raddr[k]];
      end
    end
  end

  // Stage B register; load beats end here
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en_b) begin
      b_valid <= a_valid && (a_req.cmd == tvs_pkg::CMD_SAMPLE);
    end
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      b_border <= a_border;
      b_par    <= a_par;
      b_fs     <= a_req.pos_slice[tvs_pkg::FRAC_BITS-1:0];
      b_fr     <= a_req.pos_row[tvs_pkg::FRAC_BITS-1:0];
      b_fc     <= a_req.pos_col[tvs_pkg::FRAC_BITS-1:0];
    end
  end

  // Blend along slice: route banks to corners, one lane per (col, row) pair
  always_comb begin
    logic [tvs_pkg::FRAC_BITS:0]         wgt_lo;
    logic [tvs_pkg::BANK_SEL_BITS-1:0]   sel_lo;
    logic [tvs_pkg::BANK_SEL_BITS-1:0]   sel_hi;
    wgt_lo = tvs_pkg::WGT_ONE - (tvs_pkg::FRAC_BITS + 1)'(b_fs);
    for (int dc = 0; dc < 2; dc++) begin
      for (int dr = 0; dr < 2; dr++) begin
        sel_lo = b_par ^ {1'b0, 1'(dr), 1'(dc)};
        sel_hi = b_par ^ {1'b1, 1'(dr), 1'(dc)};
        lane_next[2 * dc + dr] =
            (tvs_pkg::LANE1_BITS)'(b_rd[sel_lo]) * (tvs_pkg::LANE1_BITS)'(wgt_lo)
          + (tvs_pkg::LANE1_BITS)'(b_rd[sel_hi]) * (tvs_pkg::LANE1_BITS)'(b_fs);
      end
    end
  end

  // Stage C register
  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (en_c) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_c) begin
      c_border <= b_border;
      c_fr     <= b_fr;
      c_fc     <= b_fc;
      for (int i = 0; i < tvs_pkg::NUM_LANES; i++) begin
        c_lane[i] <= lane_next[i];
      end
    end
  end

  // Blend along row
  always_comb begin
    logic [tvs_pkg::FRAC_BITS:0] wgt_lo;
    wgt_lo = tvs_pkg::WGT_ONE - (tvs_pkg::FRAC_BITS + 1)'(c_fr);
    for (int dc = 0; dc < 2; dc++) begin
      row_next[dc] =
          (tvs_pkg::LANE2_BITS)'(c_lane[2 * dc]) * (tvs_pkg::LANE2_BITS)'(wgt_lo)
        + (tvs_pkg::LANE2_BITS)'(c_lane[2 * dc + 1]) * (tvs_pkg::LANE2_BITS)'(c_fr);
    end
  end

  // Stage D register
  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (en_d) begin
      d_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_d) begin
      d_border <= c_border;
      d_fc     <= c_fc;
      d_row[0] <= row_next[0];
      d_row[1] <= row_next[1];
    end
  end

  // Blend along column, drop the fraction, zero the border
  always_comb begin
    logic [tvs_pkg::FRAC_BITS:0] wgt_lo;
    wgt_lo = tvs_pkg::WGT_ONE - (tvs_pkg::FRAC_BITS + 1)'(d_fc);
    acc = (tvs_pkg::LANE3_BITS)'(d_row[0]) * (tvs_pkg::LANE3_BITS)'(wgt_lo)
        + (tvs_pkg::LANE3_BITS)'(d_row[1]) * (tvs_pkg::LANE3_BITS)'(d_fc);
    rsp_next.near_edge = d_border;
    if (d_border) begin
      rsp_next.sample_value = '0;
    end else begin
      rsp_next.sample_value = tvs_pkg::VALUE_BITS'(
          acc[tvs_pkg::LANE3_BITS-1:3*tvs_pkg::FRAC_BITS]);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (en_e) begin
      rsp_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_e) begin
      rsp <= rsp_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/tvs_checker.sv -----
`default_nettype none

`include "trilinear_voxel_sampler_assert.svh"

module tvs_checker (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_ready,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input tvs_pkg::tvs_rsp_t rsp
);

  // A stalled result beat holds
  `TVS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "rsp beat changed while stalled")

  // Border results carry zero
  `TVS_ASSERT_SAME(a_edge_zero, rsp_valid && rsp.near_edge, rsp.sample_value == '0, "border result is not zero")

  // Nothing leaves right after reset
  `TVS_ASSERT_SAME(a_reset_empty, $past(rst), !rsp_valid, "rsp valid right after reset")

  // With the output register empty the whole pipe can move
  `TVS_ASSERT_SAME(a_ready_chain, !rsp_valid, req_ready, "req not ready while output is empty")

  // Ready is a known level while a request beat is offered
  `TVS_ASSERT_SAME(a_req_ready_known, req_valid, !$isunknown(req_ready), "req_ready unknown")

endmodule

bind trilinear_voxel_sampler tvs_checker u_tvs_checker (.*);

`default_nettype wire

// ----- sim/trilinear_voxel_sampler_checker.sv -----
`timescale 1ns / 100ps

module trilinear_voxel_sampler_checker (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      req_valid,
  input  logic                                      req_ready,
  input  tvs_pkg::tvs_req_t                         req,
  input  logic                                      rsp_valid,
  input  logic                                      rsp_ready,
  input  tvs_pkg::tvs_rsp_t                         rsp,
  input  logic                                      cfg_valid,
  input  logic                                      cfg_ready,
  input  logic [tvs_pkg::CFG_IDX_BITS-1:0]          cfg_index,
  input  logic [tvs_pkg::CFG_BITS-1:0]              cfg_data,
  output int                                        fail_count,
  output int                                        pending,
  output int                                        edge_count,
  output int                                        interior_count
);

  typedef longint unsigned wide_t;

  localparam int VOX_ONE = 1 << tvs_pkg::FRAC_BITS;
  localparam int VOLUME  = tvs_pkg::MAX_EXTENT * tvs_pkg::MAX_EXTENT * tvs_pkg::MAX_EXTENT;

  // Shadow copy of the volume and of the extent registers
  logic [tvs_pkg::VOXEL_BITS-1:0] voxel_mem [VOLUME];
  logic [tvs_pkg::CFG_BITS-1:0]   slice_reg;
  logic [tvs_pkg::CFG_BITS-1:0]   width_reg;
  tvs_pkg::tvs_rsp_t              due_samples [$];
  int                             errors    = 0;
  int                             edges     = 0;
  int                             interiors = 0;

  function automatic int vox_addr(input int s, input int r, input int c);
    return (s * tvs_pkg::MAX_EXTENT + r) * tvs_pkg::MAX_EXTENT + c;
  endfunction

  // Registers above the built size act as the built size
  function automatic int limit_extent(input logic [tvs_pkg::CFG_BITS-1:0] n);
    return (int'(n) > tvs_pkg::MAX_EXTENT) ? tvs_pkg::MAX_EXTENT : int'(n);
  endfunction

  function automatic bit in_zero_border(input int pos, input int n);
    if (pos <= VOX_ONE) return 1'b1;
    if (n < 2) return 1'b1;
    return pos >= ((n - 2) << tvs_pkg::FRAC_BITS);
  endfunction

  function automatic wide_t vox_at(input int s, input int r, input int c);
    return wide_t'(voxel_mem[vox_addr(s, r, c)]);
  endfunction

  // One exact linear step, carrying a scale of 2^FRAC_BITS
  function automatic wide_t weigh(input wide_t a, input wide_t b, input int f);
    return a * wide_t'(VOX_ONE - f) + b * wide_t'(f);
  endfunction

  // Trilinear sample: slice first, then row, then column, truncated at the end
  function automatic tvs_pkg::tvs_rsp_t interpolate_sample(input tvs_pkg::tvs_req_t r);
    int                ns, nw, s0, r0, c0, fs, fr, fc;
    wide_t             a00, a01, a10, a11, b0, b1, acc;
    tvs_pkg::tvs_rsp_t res;
    ns = limit_extent(slice_reg);
    nw = limit_extent(width_reg);
    res.sample_value = '0;
    res.near_edge    = 1'b1;
    if (in_zero_border(int'(r.pos_slice), ns) || in_zero_border(int'(r.pos_row), nw) ||
        in_zero_border(int'(r.pos_col), nw)) begin
      return res;
    end
    s0 = int'(r.pos_slice) >> tvs_pkg::FRAC_BITS;
    r0 = int'(r.pos_row) >> tvs_pkg::FRAC_BITS;
    c0 = int'(r.pos_col) >> tvs_pkg::FRAC_BITS;
    fs = int'(r.pos_slice[tvs_pkg::FRAC_BITS-1:0]);
    fr = int'(r.pos_row[tvs_pkg::FRAC_BITS-1:0]);
    fc = int'(r.pos_col[tvs_pkg::FRAC_BITS-1:0]);
    a00 = weigh(vox_at(s0, r0, c0), vox_at(s0 + 1, r0, c0), fs);
    a01 = weigh(vox_at(s0, r0 + 1, c0), vox_at(s0 + 1, r0 + 1, c0), fs);
    a10 = weigh(vox_at(s0, r0, c0 + 1), vox_at(s0 + 1, r0, c0 + 1), fs);
    a11 = weigh(vox_at(s0, r0 + 1, c0 + 1), vox_at(s0 + 1, r0 + 1, c0 + 1), fs);
    b0  = weigh(a00, a01, fr);
    b1  = weigh(a10, a11, fr);
    acc = weigh(b0, b1, fc);
    res.sample_value = tvs_pkg::VALUE_BITS'(acc >> (3 * tvs_pkg::FRAC_BITS));
    res.near_edge    = 1'b0;
    return res;
  endfunction

  always @(posedge clk) begin : watch
    tvs_pkg::tvs_rsp_t want;
    if (rst) begin
      slice_reg = tvs_pkg::EXTENT_RESET;
      width_reg = tvs_pkg::EXTENT_RESET;
      due_samples.delete();
    end else begin
      // Track register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          tvs_pkg::CFG_SLICE_COUNT:  slice_reg = cfg_data;
          tvs_pkg::CFG_WIDTH_IN_USE: width_reg = cfg_data;
          default: ;
        endcase
      end

      // Match each result beat against the oldest prediction
      if (rsp_valid && rsp_ready) begin
        if (due_samples.size() == 0) begin
          $display("%0t: result beat, expected none, actual value %h near_edge %b",
                   $time, rsp.sample_value, rsp.near_edge);
          errors++;
        end else begin
          want = due_samples.pop_front();
          if (rsp.sample_value !== want.sample_value) begin
            $display("%0t: sample_value mismatch, expected %h, actual %h",
                     $time, want.sample_value, rsp.sample_value);
            errors++;
          end
          if (rsp.near_edge !== want.near_edge) begin
            $display("%0t: near_edge mismatch, expected %b, actual %b",
                     $time, want.near_edge, rsp.near_edge);
            errors++;
          end
        end
      end

      // Apply a load or predict a sample for each request beat
      if (req_valid && req_ready) begin
        if (req.cmd == tvs_pkg::CMD_LOAD) begin
          voxel_mem[vox_addr(int'(req.load_slice), int'(req.load_row), int'(req.load_col))]
            = req.voxel_value[tvs_pkg::VOXEL_BITS-1:0];
        end else begin
          want = interpolate_sample(req);
          due_samples.insert(due_samples.size(), want);
          if (want.near_edge) edges++;
          else interiors++;
        end
      end
    end

    // Publish counts once per edge
    fail_count     <= errors;
    pending        <= due_samples.size();
    edge_count     <= edges;
    interior_count <= interiors;
  end

endmodule

// ----- sim/trilinear_voxel_sampler_test.sv -----
`timescale 1ns / 100ps

module trilinear_voxel_sampler_test;

  localparam int RESET_CYCLES   = 6;
  localparam int IDLE_PCT       = 12;
  localparam int HOLD_CYCLES    = 200;
  localparam int SETTLE_CYCLES  = 12;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_EXT        = tvs_pkg::MAX_EXTENT;
  localparam int IDX_W          = tvs_pkg::IDX_FIELD_BITS;
  localparam int VAL_W          = tvs_pkg::VALUE_BITS;
  localparam int POS_W          = tvs_pkg::POS_BITS;
  localparam int VOX_ONE        = 1 << tvs_pkg::FRAC_BITS;
  localparam int POS_MAX        = (1 << POS_W) - 1;
  localparam int VOLUME         = MAX_EXT * MAX_EXT * MAX_EXT;

  // Index with no register behind it
  localparam logic [tvs_pkg::CFG_IDX_BITS-1:0] CFG_SPARE = tvs_pkg::CFG_IDX_BITS'(3);

  logic                                 clk       = 1'b0;
  logic                                 rst       = 1'b1;
  logic                                 req_valid = 1'b0;
  logic                                 req_ready;
  tvs_pkg::tvs_req_t                    req       = '0;
  logic                                 rsp_valid;
  logic                                 rsp_ready = 1'b0;
  tvs_pkg::tvs_rsp_t                    rsp;
  logic                                 cfg_valid = 1'b0;
  logic                                 cfg_ready;
  logic [tvs_pkg::CFG_IDX_BITS-1:0]     cfg_index = '0;
  logic [tvs_pkg::CFG_BITS-1:0]         cfg_data  = '0;

  int fail_count;
  int pending;
  int edge_count;
  int interior_count;

  // Sender-side bookkeeping
  bit                 written_map [VOLUME];
  logic [3*IDX_W-1:0] loaded_cubes [$];
  int                 cur_slices = MAX_EXT;
  int                 cur_width  = MAX_EXT;
  int                 items_sent = 0;
  int                 loads_sent = 0;
  bit                 steady     = 1'b0;
  logic               start_hold = 1'b0;

  // Receiver-side state
  int results_taken = 0;
  int hold_left     = 0;
  bit hold_done     = 1'b0;

  // Watchdog
  int idle_cycles = 0;

  always #1 clk = ~clk;

  trilinear_voxel_sampler u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  trilinear_voxel_sampler_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_ready      (req_ready),
    .req            (req),
    .rsp_valid      (rsp_valid),
    .rsp_ready      (rsp_ready),
    .rsp            (rsp),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .fail_count     (fail_count),
    .pending        (pending),
    .edge_count     (edge_count),
    .interior_count (interior_count)
  );

  // Drain results, with random stalls, one long hold-off and a calm stretch
  always @(posedge clk) begin
    if (rsp_valid && rsp_ready) results_taken++;
    if (hold_left > 0) begin
      hold_left--;
      rsp_ready <= 1'b0;
    end else if (start_hold && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      rsp_ready <= 1'b0;
    end else if (results_taken >= 100 && results_taken < 150) begin
      rsp_ready <= 1'b1;
    end else begin
      rsp_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // End the run when no beat moves for too long
  always @(posedge clk) begin
    if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout after %0d cycles without a beat", WATCHDOG_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic int vox_addr(input int s, input int r, input int c);
    return (s * MAX_EXT + r) * MAX_EXT + c;
  endfunction

  // Request with every field random; callers set the ones that matter
  function automatic tvs_pkg::tvs_req_t scatter_fields();
    tvs_pkg::tvs_req_t it;
    it.cmd         = 1'($urandom);
    it.load_slice  = IDX_W'($urandom);
    it.load_row    = IDX_W'($urandom);
    it.load_col    = IDX_W'($urandom);
    it.voxel_value = VAL_W'($urandom);
    it.pos_slice   = POS_W'($urandom);
    it.pos_row     = POS_W'($urandom);
    it.pos_col     = POS_W'($urandom);
    return it;
  endfunction

  function automatic tvs_pkg::tvs_req_t load_item(input int s, input int r, input int c,
                                                  input logic [VAL_W-1:0] v);
    tvs_pkg::tvs_req_t it;
    it             = scatter_fields();
    it.cmd         = tvs_pkg::CMD_LOAD;
    it.load_slice  = IDX_W'(s);
    it.load_row    = IDX_W'(r);
    it.load_col    = IDX_W'(c);
    it.voxel_value = v;
    return it;
  endfunction

  function automatic tvs_pkg::tvs_req_t sample_item(input int ps, input int pr, input int pc);
    tvs_pkg::tvs_req_t it;
    it           = scatter_fields();
    it.cmd       = tvs_pkg::CMD_SAMPLE;
    it.pos_slice = POS_W'(ps);
    it.pos_row   = POS_W'(pr);
    it.pos_col   = POS_W'(pc);
    return it;
  endfunction

  // Fraction with extra weight on both ends
  function automatic int pick_frac();
    case ($urandom_range(0, 6))
      0:       return 0;
      1:       return VOX_ONE - 1;
      default: return $urandom_range(0, VOX_ONE - 1);
    endcase
  endfunction

  function automatic tvs_pkg::tvs_req_t sample_in_cube(input int s, input int r, input int c);
    return sample_item(s * VOX_ONE + pick_frac(), r * VOX_ONE + pick_frac(),
                       c * VOX_ONE + pick_frac());
  endfunction

  // Lowest corner of a cube that lies inside the border, where the axis allows one
  function automatic int pick_cube_base(input int extent);
    int n;
    n = (extent > MAX_EXT) ? MAX_EXT : extent;
    if (n >= 4) return $urandom_range(1, n - 3);
    return $urandom_range(1, MAX_EXT - 3);
  endfunction

  // True when all eight voxels around a point have been loaded
  function automatic bit corners_written(input int ps, input int pr, input int pc);
    int s0, r0, c0;
    s0 = ps >> tvs_pkg::FRAC_BITS;
    r0 = pr >> tvs_pkg::FRAC_BITS;
    c0 = pc >> tvs_pkg::FRAC_BITS;
    if (s0 + 1 >= MAX_EXT || r0 + 1 >= MAX_EXT || c0 + 1 >= MAX_EXT) return 1'b0;
    for (int k = 0; k < 8; k++) begin
      if (!written_map[vox_addr(s0 + ((k >> 2) & 1), r0 + ((k >> 1) & 1), c0 + (k & 1))])
        return 1'b0;
    end
    return 1'b1;
  endfunction

  // Offer one request beat, with random gaps ahead of it
  task automatic send_item(input tvs_pkg::tvs_req_t item);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    if (item.cmd == tvs_pkg::CMD_LOAD) begin
      written_map[vox_addr(int'(item.load_slice), int'(item.load_row),
                           int'(item.load_col))] = 1'b1;
      loads_sent++;
    end
    req       <= item;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic write_reg(input logic [tvs_pkg::CFG_IDX_BITS-1:0] idx,
                           input logic [tvs_pkg::CFG_BITS-1:0] value);
    cfg_index <= idx;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Stop offering, wait for every predicted result, then let the pipe empty
  task automatic settle();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Load eight corners of one cube and record the cube for later samples
  task automatic load_cube(input int s, input int r, input int c, input int mode);
    logic [VAL_W-1:0] fill;
    for (int k = 0; k < 8; k++) begin
      case (mode)
        0:       fill = '1;
        1:       fill = '0;
        2:       fill = VAL_W'(k * 16'h2222);
        default: fill = VAL_W'($urandom);
      endcase
      send_item(load_item(s + ((k >> 2) & 1), r + ((k >> 1) & 1), c + (k & 1), fill));
    end
    loaded_cubes.insert(loaded_cubes.size(), {IDX_W'(s), IDX_W'(r), IDX_W'(c)});
  endtask

  // Extremes of the fields, both sides of the slice border and of the top column border, at full extent
  task automatic directed_part();
    int top;
    top = (MAX_EXT - 2) * VOX_ONE;
    send_item(load_item(MAX_EXT - 1, MAX_EXT - 1, MAX_EXT - 1, '1));
    send_item(load_item(0, 0, 0, '0));
    load_cube(1, 1, 1, 0);
    send_item(sample_item(VOX_ONE + 1, VOX_ONE + 1, VOX_ONE + 1));
    send_item(sample_item(2 * VOX_ONE - 1, 2 * VOX_ONE - 1, 2 * VOX_ONE - 1));
    send_item(sample_item(VOX_ONE, VOX_ONE + 100, VOX_ONE + 100));
    send_item(sample_item(0, 0, 0));
    send_item(sample_item(POS_MAX, POS_MAX, POS_MAX));
    load_cube(MAX_EXT - 3, MAX_EXT - 3, MAX_EXT - 3, 2);
    send_item(sample_item(top - 1, top - 1, top - 1));
    send_item(sample_item(top, top - 1, top - 1));
    send_item(sample_item(top - 1, top - 1, top));
  endtask

  // Mostly load-then-sample sequences, plus resamples, raw points and stray loads
  task automatic random_traffic(input int count);
    int                 target, pick, s, r, c, ps, pr, pc;
    logic [3*IDX_W-1:0] cube;
    target = items_sent + count;
    while (items_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 35 || loaded_cubes.size() == 0) begin
        s = pick_cube_base(cur_slices);
        r = pick_cube_base(cur_width);
        c = pick_cube_base(cur_width);
        load_cube(s, r, c, $urandom_range(0, 9));
        repeat ($urandom_range(1, 3)) send_item(sample_in_cube(s, r, c));
      end else if (pick < 70) begin
        cube = loaded_cubes[$urandom_range(0, loaded_cubes.size() - 1)];
        send_item(sample_in_cube(int'(cube[3*IDX_W-1 -: IDX_W]),
                                 int'(cube[2*IDX_W-1 -: IDX_W]),
                                 int'(cube[IDX_W-1:0])));
      end else if (pick < 85) begin
        ps = $urandom_range(0, POS_MAX);
        pr = $urandom_range(0, POS_MAX);
        pc = $urandom_range(0, POS_MAX);
        // Push the point into the border unless its voxels are known
        if (!corners_written(ps, pr, pc)) ps = $urandom_range(0, VOX_ONE);
        send_item(sample_item(ps, pr, pc));
      end else begin
        send_item(load_item($urandom_range(0, MAX_EXT - 1), $urandom_range(0, MAX_EXT - 1),
                            $urandom_range(0, MAX_EXT - 1), VAL_W'($urandom)));
      end
    end
  endtask

  task automatic run_phase(input int slices, input int width, input int count,
                           input bit squeeze);
    settle();
    write_reg(tvs_pkg::CFG_SLICE_COUNT, tvs_pkg::CFG_BITS'(slices));
    write_reg(tvs_pkg::CFG_WIDTH_IN_USE, tvs_pkg::CFG_BITS'(width));
    cur_slices = slices;
    cur_width  = width;
    if (squeeze) start_hold <= 1'b1;
    random_traffic(count);
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed_part();
    random_traffic(110);
    run_phase(4, 127, 50, 1'b0);
    run_phase(0, 2, 15, 1'b0);
    settle();
    write_reg(CFG_SPARE, tvs_pkg::CFG_BITS'($urandom));
    run_phase(127, 4, 50, 1'b0);
    run_phase(1, 3, 15, 1'b0);
    steady = 1'b1;
    run_phase($urandom_range(5, MAX_EXT), $urandom_range(5, MAX_EXT), 60, 1'b0);
    steady = 1'b0;
    run_phase(MAX_EXT, MAX_EXT + 1, 80, 1'b1);
    settle();

    $display("Drove %0d voxel loads and %0d samples over seven extent settings.",
             loads_sent, items_sent - loads_sent);
    $display("%0d samples interpolated inside the volume, %0d landed in the zero border.",
             interior_count, edge_count);
    if (fail_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/tvs_pkg.sv
rtl/core/trilinear_voxel_sampler.sv
rtl/core/tvs_checker.sv
sim/trilinear_voxel_sampler_checker.sv
sim/trilinear_voxel_sampler_test.sv
